// File: src/mhs_pkg.sv
// ----------------------------------------------------------------------------
// mhs_pkg
// Shared constants and types of the module header scanner: window geometry,
// address widths, header marker words and configuration register indexes.
// ----------------------------------------------------------------------------
package mhs_pkg;

    // Number of 16-bit words covered by one header and its check word.
    localparam int HEADER_WORDS = 25;
    // Width of a byte address.
    localparam int ADDRESS_BITS = 24;

    localparam int WORD_BITS       = 16;
    localparam int SIZE_BITS       = 32;
    localparam int SKIP_BITS       = SIZE_BITS - 1;
    localparam int REGION_END_BITS = ADDRESS_BITS + 1;
    localparam int CFG_DATA_BITS   = REGION_END_BITS;
    localparam int CFG_INDEX_BITS  = 1;

    // The four oldest window words live in registers, the rest in a memory.
    localparam int HEAD_WORDS    = 4;
    localparam int HEAD_IDX_BITS = $clog2(HEAD_WORDS);
    localparam int MEM_DEPTH     = HEADER_WORDS - HEAD_WORDS;
    localparam int PTR_BITS      = $clog2(MEM_DEPTH);
    localparam int FILL_BITS     = $clog2(HEADER_WORDS + 1);

    localparam logic [WORD_BITS-1:0] SYNC_WORD   = 16'h4AFC;
    localparam logic [WORD_BITS-1:0] SYSREV_WORD = 16'h0001;
    localparam logic [WORD_BITS-1:0] PARITY_SEED = 16'hFFFF;

    localparam logic [ADDRESS_BITS-1:0]    REGION_START_RESET = '0;
    localparam logic [REGION_END_BITS-1:0] REGION_END_RESET   =
        REGION_END_BITS'(32'h0008_0000);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_REGION_START = 1'b0,
        CFG_REGION_END   = 1'b1
    } cfg_reg_t;

    typedef logic [WORD_BITS-1:0] word_t;

endpackage

// File: src/module_header_scanner.sv
// ----------------------------------------------------------------------------
// module_header_scanner
// Streams memory words of a scan region through a sliding header window and
// reports every valid module header with its byte address and size.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one big-endian 16-bit
// memory word per request, in ascending address order. A request with
// first_word set starts a new pass: the window, its XOR and any pending skip
// are dropped, and the word is taken to sit at region_start.
// The output channel (out_valid / out_stall) carries one request per module
// header found: its byte address and the 32-bit size from header words two
// and three. Positions inside a reported module are not examined again.
// Throughput is one word per clock while in_stall is low, set by the single
// window memory, which each word reads once and writes at most once. A
// result is registered on out_valid when the output register is free.
// The output register is backed by a one-entry skid buffer, so words keep
// flowing while a result waits; in_stall rises only while the skid buffer
// holds a result, that is after a second result met a stalled receiver.
// Reset clears all control state and loads region_start = 0 and
// region_end = 0x080000; there is no clearing pass, so words are accepted in
// the first cycle after reset. Words fed before any pass start are scanned
// from address zero. The user writes the region registers via cfg_write,
// cfg_index and cfg_data only while the scanner is idle; no logic enforces it.
// ----------------------------------------------------------------------------
module module_header_scanner (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  cfg_write,
    input  logic [mhs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [mhs_pkg::CFG_DATA_BITS-1:0]     cfg_data,

    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [mhs_pkg::WORD_BITS-1:0]         word_data,
    input  logic                                  first_word,

    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [mhs_pkg::ADDRESS_BITS-1:0]      module_address,
    output logic [mhs_pkg::SIZE_BITS-1:0]         module_size
);

    // Configuration registers.
    logic [mhs_pkg::ADDRESS_BITS-1:0]    region_start_reg;
    logic [mhs_pkg::REGION_END_BITS-1:0] region_end_reg;

    // Scan state. The window is head_reg[0..3] followed by the memory
    // entries from ptr_reg (oldest) around to ptr_reg - 1 (newest).
    mhs_pkg::word_t                      head_reg [mhs_pkg::HEAD_WORDS];
    mhs_pkg::word_t                      head_next [mhs_pkg::HEAD_WORDS];
    logic [mhs_pkg::WORD_BITS-1:0]       xor_reg, xor_next;
    logic [mhs_pkg::FILL_BITS-1:0]       fill_reg, fill_next;
    logic [mhs_pkg::ADDRESS_BITS-1:0]    cand_reg, cand_next;
    logic [mhs_pkg::SKIP_BITS-1:0]       skip_reg, skip_next;
    logic [mhs_pkg::PTR_BITS-1:0]        ptr_reg, ptr_next;

    // Window memory.
    mhs_pkg::word_t                      win_mem [mhs_pkg::MEM_DEPTH];
    mhs_pkg::word_t                      rd_data_reg;
    logic                                mem_we;
    logic [mhs_pkg::PTR_BITS-1:0]        mem_wa;

    // Output register and skid buffer.
    logic                                out_valid_reg, skid_valid_reg;
    logic [mhs_pkg::ADDRESS_BITS-1:0]    out_addr_reg, skid_addr_reg;
    logic [mhs_pkg::SIZE_BITS-1:0]       out_size_reg, skid_size_reg;

    // Per-word datapath.
    logic                                in_accept;
    logic                                pop;
    logic [mhs_pkg::FILL_BITS-1:0]       fill_eff;
    logic [mhs_pkg::WORD_BITS-1:0]       xor_eff;
    logic [mhs_pkg::ADDRESS_BITS-1:0]    cand_eff;
    logic [mhs_pkg::SKIP_BITS-1:0]       skip_eff;
    logic [mhs_pkg::SKIP_BITS-1:0]       skip_dec;
    logic                                full;
    logic                                report;
    logic [mhs_pkg::SIZE_BITS-1:0]       size_next;

    assign in_accept = in_valid && !in_stall;
    assign pop       = out_valid_reg && !out_stall;
    assign in_stall  = skid_valid_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= mhs_pkg::REGION_START_RESET;
            region_end_reg   <= mhs_pkg::REGION_END_RESET;
        end
        else if (cfg_write)
        begin
            unique case (mhs_pkg::cfg_reg_t'(cfg_index))
                mhs_pkg::CFG_REGION_START:
                    region_start_reg <= cfg_data[mhs_pkg::ADDRESS_BITS-1:0];
                mhs_pkg::CFG_REGION_END:
                    region_end_reg <= cfg_data[mhs_pkg::REGION_END_BITS-1:0];
                default:
                    region_end_reg <= region_end_reg;
            endcase
        end
    end

    // Effective state for this word: a pass start drops the old window.
    always_comb
    begin
        fill_eff = first_word ? '0 : fill_reg;
        xor_eff  = first_word ? '0 : xor_reg;
        cand_eff = first_word ? region_start_reg : cand_reg;
        skip_eff = first_word ? '0 : skip_reg;
        full     = (fill_eff == mhs_pkg::FILL_BITS'(mhs_pkg::HEADER_WORDS));
    end

    // Window update, running XOR and header check.
    always_comb
    begin
        for (int i = 0; i < mhs_pkg::HEAD_WORDS; i++)
        begin
            head_next[i] = head_reg[i];
        end
        xor_next  = xor_eff ^ word_data;
        cand_next = cand_eff;
        skip_dec  = skip_eff;
        fill_next = fill_eff;
        mem_we    = 1'b0;
        mem_wa    = ptr_reg;
        ptr_next  = first_word ? '0 : ptr_reg;

        if (full)
        begin
            // Oldest word leaves, oldest memory word moves into the head.
            xor_next = xor_eff ^ head_reg[0] ^ word_data;
            for (int i = 0; i < mhs_pkg::HEAD_WORDS - 1; i++)
            begin
                head_next[i] = head_reg[i + 1];
            end
            head_next[mhs_pkg::HEAD_WORDS-1] = rd_data_reg;
            cand_next = cand_eff + mhs_pkg::ADDRESS_BITS'(2);
            if (skip_eff != '0)
            begin
                skip_dec = skip_eff - mhs_pkg::SKIP_BITS'(1);
            end
            mem_we = 1'b1;
            mem_wa = ptr_reg;
            if (ptr_reg == mhs_pkg::PTR_BITS'(mhs_pkg::MEM_DEPTH - 1))
            begin
                ptr_next = '0;
            end
            else
            begin
                ptr_next = ptr_reg + mhs_pkg::PTR_BITS'(1);
            end
        end
        else
        begin
            fill_next = fill_eff + mhs_pkg::FILL_BITS'(1);
            if (fill_eff < mhs_pkg::FILL_BITS'(mhs_pkg::HEAD_WORDS))
            begin
                head_next[fill_eff[mhs_pkg::HEAD_IDX_BITS-1:0]] = word_data;
            end
            else
            begin
                mem_we = 1'b1;
                mem_wa = mhs_pkg::PTR_BITS'(fill_eff -
                                            mhs_pkg::FILL_BITS'(mhs_pkg::HEAD_WORDS));
            end
        end

        if (!in_accept)
        begin
            mem_we   = 1'b0;
            ptr_next = ptr_reg;
        end

        size_next = {head_next[2], head_next[3]};
        report = (fill_next == mhs_pkg::FILL_BITS'(mhs_pkg::HEADER_WORDS))
              && (skip_dec == '0)
              && ({1'b0, cand_next} < region_end_reg)
              && (head_next[0] == mhs_pkg::SYNC_WORD)
              && (head_next[1] == mhs_pkg::SYSREV_WORD)
              && ((xor_next ^ mhs_pkg::PARITY_SEED) == '0);

        // A report skips the module body; odd sizes round down.
        skip_next = report ? size_next[mhs_pkg::SIZE_BITS-1:1] : skip_dec;
    end

    // Window memory: at most one write and one registered read per clock. The
    // read address is the next oldest entry, so its data is ready for the next
    // word; in a full window it is never the address written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[mem_wa] <= word_data;
        end
        rd_data_reg <= win_mem[ptr_next];
    end

    // Scan control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xor_reg  <= '0;
            fill_reg <= '0;
            cand_reg <= '0;
            skip_reg <= '0;
            ptr_reg  <= '0;
        end
        else if (in_accept)
        begin
            xor_reg  <= xor_next;
            fill_reg <= fill_next;
            cand_reg <= cand_next;
            skip_reg <= skip_next;
            ptr_reg  <= ptr_next;
        end
    end

    // Head words are only read once the fill count says they are written.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int i = 0; i < mhs_pkg::HEAD_WORDS; i++)
            begin
                head_reg[i] <= head_next[i];
            end
        end
    end

    // Output register with skid buffer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_accept && report;
            end
        end
        else if (in_accept && report)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_addr_reg <= skid_addr_reg;
                out_size_reg <= skid_size_reg;
            end
            else
            begin
                out_addr_reg <= cand_next;
                out_size_reg <= size_next;
            end
        end
        else if (in_accept && report)
        begin
            skid_addr_reg <= cand_next;
            skid_size_reg <= size_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign module_address = out_addr_reg;
    assign module_size    = out_size_reg;

    // The skid buffer is only filled behind a waiting result.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid buffer holds a result while the output is empty");

    // The fill count never passes the window length.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= mhs_pkg::FILL_BITS'(mhs_pkg::HEADER_WORDS))
        else $error("window fill count out of range");

    // A result that meets a stalled receiver lands in the skid buffer.
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && report && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("result lost behind a stalled output");

    // A report of a module of two bytes or more starts a skip.
    a_skip_started: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && report && (size_next[mhs_pkg::SIZE_BITS-1:1] != '0))
        |=> (skip_reg != '0))
        else $error("reported module body not skipped");

endmodule
